[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the gamepad poll decoder.
// Each macro expands to one labelled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/gspd_pkg.sv]
// Package for the gamepad serial poll decoder: constants, register indexes and helpers.
// Used by gamepad_serial_poll_decoder_top; depends on nothing.
`timescale 1ns / 1ps

package gspd_pkg;

   // Frame length and counter widths
   localparam int FRAME_BYTES_DEF = 9;
   localparam int BYTE_CNT_W      = 4;
   localparam int BIT_CNT_W       = 3;

   // Bytes sent at the head of every frame, the idle byte, and the mode byte of red mode
   localparam logic [7:0] TX_START  = 8'h01;
   localparam logic [7:0] TX_POLL   = 8'h42;
   localparam logic [7:0] TX_IDLE   = 8'h00;
   localparam logic [7:0] MODE_RED  = 8'h73;

   // Positions of the motor bytes sent and of the captured bytes within a frame
   localparam logic [BYTE_CNT_W-1:0] BYTE_MODE    = 4'd1;
   localparam logic [BYTE_CNT_W-1:0] BYTE_MOTOR_S = 4'd3;
   localparam logic [BYTE_CNT_W-1:0] BYTE_MOTOR_L = 4'd4;
   localparam logic [BYTE_CNT_W-1:0] BYTE_BTN_LO  = 4'd3;
   localparam logic [BYTE_CNT_W-1:0] BYTE_BTN_HI  = 4'd4;
   localparam logic [BYTE_CNT_W-1:0] BYTE_RX      = 4'd5;
   localparam logic [BYTE_CNT_W-1:0] BYTE_RY      = 4'd6;
   localparam logic [BYTE_CNT_W-1:0] BYTE_LX      = 4'd7;
   localparam logic [BYTE_CNT_W-1:0] BYTE_LY      = 4'd8;

   // Stick centres and register reset values
   localparam logic [7:0] X_CENTRE        = 8'd128;
   localparam logic [7:0] Y_CENTRE        = 8'd127;
   localparam logic [7:0] X_DEAD_LOW_RST  = 8'd123;
   localparam logic [7:0] X_DEAD_HIGH_RST = 8'd133;
   localparam logic [7:0] Y_DEAD_LOW_RST  = 8'd122;
   localparam logic [7:0] Y_DEAD_HIGH_RST = 8'd132;
   localparam logic [7:0] RUMBLE_RST      = 8'hFF;

   // Keys that request one of the two motors
   localparam logic [4:0] KEY_NONE    = 5'd0;
   localparam logic [4:0] KEY_LARGE_A = 5'd9;
   localparam logic [4:0] KEY_SMALL_A = 5'd10;
   localparam logic [4:0] KEY_LARGE_B = 5'd11;
   localparam logic [4:0] KEY_SMALL_B = 5'd12;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_X_DEAD_LOW  = 3'd0,
      CSR_X_DEAD_HIGH = 3'd1,
      CSR_Y_DEAD_LOW  = 3'd2,
      CSR_Y_DEAD_HIGH = 3'd3,
      CSR_RUMBLE      = 3'd4
   } csr_index_type;

   // Lowest clear bit of the active-low button word, as key 1..16, or none.
   function automatic logic [4:0] first_pressed(input logic [15:0] buttons);
      logic [4:0] key;
      key = KEY_NONE;
      for (int i = 15; i >= 0; i--) begin
         if (!buttons[i]) begin
            key = 5'(i + 1);
         end
      end
      return key;
   endfunction

   // Snap a stick byte to the centre when it lies strictly inside the deadzone.
   function automatic logic [7:0] snap(input logic [7:0] v, input logic [7:0] lo,
                                       input logic [7:0] hi, input logic [7:0] centre);
      return ((v > lo) && (v < hi)) ? centre : v;
   endfunction

endpackage

[sv/gamepad_serial_poll_decoder_top.sv]
// Top level of the gamepad serial poll decoder: bit engine, result decode and output buffer.
// Depends on gspd_pkg and on the assertion macros in assert_macros.svh.
`timescale 1ns / 1ps

// The block takes one word per clock cycle, a bit tick or a frame start, and gives exactly one
// result word for each. Results are registered in an output register; a second register behind
// it lets the input keep taking a word while a result still waits, so the input stalls only
// when both are full. All decoding of a finished read frame (key priority, deadzone snapping,
// stick offsets, motor bytes) is done in the same cycle as the last bit tick. Configuration
// writes take effect at the next edge.
module gamepad_serial_poll_decoder_top #(
   parameter int FRAME_BYTES = gspd_pkg::FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] din, [7:1] zero
   input  logic        req_tuser,   // [0] command: 0 bit tick, 1 start frame
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] dout, [1] select_active, [6:2] key, [14:7] left_x,
                                    // [22:15] left_y, [30:23] right_x, [38:31] right_y,
                                    // [39] mode_red
   output logic        rsp_tlast,   // frame_done
   // Configuration port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import gspd_pkg::*;

`include "assert_macros.svh"

   localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(FRAME_BYTES - 1);
   localparam logic [BIT_CNT_W-1:0]  LAST_BIT  = '1;

   // Configuration registers
   logic [7:0] x_dead_low_ff, x_dead_high_ff, y_dead_low_ff, y_dead_high_ff, rumble_ff;

   // Frame state
   logic                  frame_is_rumble_ff, frame_is_rumble_in;
   logic                  busy_ff, busy_in;
   logic [BYTE_CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [BIT_CNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [7:0]            rx_shift_ff, rx_shift_in;
   logic [7:0]            mode_byte_ff, mode_byte_in;
   logic [15:0]           button_ff, button_in;
   logic [7:0]            stick_ff [4];
   logic [7:0]            stick_in [4];
   logic [7:0]            motor_small_ff, motor_small_in;
   logic [7:0]            motor_large_ff, motor_large_in;

   // Output register and skid register
   logic        out_valid_ff, out_valid_in;
   logic [39:0] out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [39:0] skid_data_ff, skid_data_in;
   logic        skid_last_ff, skid_last_in;

   // Decode of the accepted word
   logic        accept, cmd, din;
   logic        byte_end, frame_end;
   logic [7:0]  rx_next, tx_byte;
   logic [4:0]  key;
   logic [7:0]  rx_snap, ry_snap, lx_snap, ly_snap;
   logic        res_dout, res_sel, res_done, res_red;
   logic [4:0]  res_key;
   logic [7:0]  res_lx, res_ly, res_rx, res_ry;
   logic [39:0] res_data;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tuser;
   assign din        = req_tdata[0];
   assign rx_next    = {din, rx_shift_ff[7:1]};
   assign byte_end   = (bit_count_ff == LAST_BIT);
   assign frame_end  = byte_end && (byte_count_ff == LAST_BYTE);

   // Byte driven to the pad in the current byte slot
   always_comb begin
      case (byte_count_ff)
         4'd0:         tx_byte = TX_START;
         4'd1:         tx_byte = TX_POLL;
         BYTE_MOTOR_S: tx_byte = frame_is_rumble_ff ? motor_small_ff : TX_IDLE;
         BYTE_MOTOR_L: tx_byte = frame_is_rumble_ff ? motor_large_ff : TX_IDLE;
         default:      tx_byte = TX_IDLE;
      endcase
   end

   // Bit engine: counters, receive shifter and byte capture
   always_comb begin
      frame_is_rumble_in = frame_is_rumble_ff;
      busy_in            = busy_ff;
      byte_count_in      = byte_count_ff;
      bit_count_in       = bit_count_ff;
      rx_shift_in        = rx_shift_ff;
      mode_byte_in       = mode_byte_ff;
      button_in          = button_ff;
      stick_in           = stick_ff;
      if (accept && cmd) begin
         busy_in       = 1'b1;
         byte_count_in = '0;
         bit_count_in  = '0;
         rx_shift_in   = '0;
      end else if (accept && busy_ff) begin
         if (!byte_end) begin
            bit_count_in = bit_count_ff + 1'b1;
            rx_shift_in  = rx_next;
         end else begin
            bit_count_in = '0;
            rx_shift_in  = '0;
            if (!frame_is_rumble_ff) begin
               case (byte_count_ff)
                  BYTE_MODE:   mode_byte_in      = rx_next;
                  BYTE_BTN_LO: button_in[7:0]    = rx_next;
                  BYTE_BTN_HI: button_in[15:8]   = rx_next;
                  BYTE_RX:     stick_in[0]       = rx_next;
                  BYTE_RY:     stick_in[1]       = rx_next;
                  BYTE_LX:     stick_in[2]       = rx_next;
                  BYTE_LY:     stick_in[3]       = rx_next;
                  default:     mode_byte_in      = mode_byte_ff;
               endcase
            end
            if (frame_end) begin
               busy_in            = 1'b0;
               byte_count_in      = '0;
               frame_is_rumble_in = !frame_is_rumble_ff;
            end else begin
               byte_count_in = byte_count_ff + 1'b1;
            end
         end
      end
   end

   // Read frame decode, taken from the values that include the last byte
   assign key     = first_pressed(button_in);
   assign rx_snap = snap(stick_in[0], x_dead_low_ff, x_dead_high_ff, X_CENTRE);
   assign ry_snap = snap(stick_in[1], y_dead_low_ff, y_dead_high_ff, Y_CENTRE);
   assign lx_snap = snap(stick_in[2], x_dead_low_ff, x_dead_high_ff, X_CENTRE);
   assign ly_snap = snap(stick_in[3], y_dead_low_ff, y_dead_high_ff, Y_CENTRE);

   // Motor bytes for the next frame are picked when a read frame ends
   always_comb begin
      motor_small_in = motor_small_ff;
      motor_large_in = motor_large_ff;
      if (accept && !cmd && busy_ff && frame_end && !frame_is_rumble_ff) begin
         if ((key == KEY_LARGE_A) || (key == KEY_LARGE_B)) begin
            motor_small_in = '0;
            motor_large_in = rumble_ff;
         end else if ((key == KEY_SMALL_A) || (key == KEY_SMALL_B)) begin
            motor_small_in = rumble_ff;
            motor_large_in = '0;
         end else begin
            motor_small_in = '0;
            motor_large_in = '0;
         end
      end
   end

   // Result word of the accepted item
   always_comb begin
      res_done = !cmd && busy_ff && frame_end && !frame_is_rumble_ff;
      res_sel  = cmd || busy_ff;
      res_dout = !cmd && busy_ff && tx_byte[bit_count_ff];
      res_key  = res_done ? key : '0;
      res_lx   = res_done ? (lx_snap ^ 8'h80) : '0;
      res_rx   = res_done ? (rx_snap ^ 8'h80) : '0;
      res_ly   = res_done ? (Y_CENTRE - ly_snap) : '0;
      res_ry   = res_done ? (Y_CENTRE - ry_snap) : '0;
      res_red  = res_done && (mode_byte_in == MODE_RED);
      res_data = {res_red, res_ry, res_rx, res_ly, res_lx, res_key, res_sel, res_dout};
   end

   // Output register with a skid register behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_last_in  = skid_last_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = res_data;
            out_last_in  = res_done;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
         skid_last_in  = res_done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_dead_low_ff  <= X_DEAD_LOW_RST;
         x_dead_high_ff <= X_DEAD_HIGH_RST;
         y_dead_low_ff  <= Y_DEAD_LOW_RST;
         y_dead_high_ff <= Y_DEAD_HIGH_RST;
         rumble_ff      <= RUMBLE_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_X_DEAD_LOW:  x_dead_low_ff  <= csr_wdata;
            CSR_X_DEAD_HIGH: x_dead_high_ff <= csr_wdata;
            CSR_Y_DEAD_LOW:  y_dead_low_ff  <= csr_wdata;
            CSR_Y_DEAD_HIGH: y_dead_high_ff <= csr_wdata;
            CSR_RUMBLE:      rumble_ff      <= csr_wdata;
            default:         rumble_ff      <= rumble_ff;
         endcase
      end
   end

   // Frame state and output buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_is_rumble_ff <= 1'b0;
         busy_ff            <= 1'b0;
         byte_count_ff      <= '0;
         bit_count_ff       <= '0;
         rx_shift_ff        <= '0;
         mode_byte_ff       <= '0;
         button_ff          <= '1;
         stick_ff           <= '{default: '0};
         motor_small_ff     <= '0;
         motor_large_ff     <= '0;
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         frame_is_rumble_ff <= frame_is_rumble_in;
         busy_ff            <= busy_in;
         byte_count_ff      <= byte_count_in;
         bit_count_ff       <= bit_count_in;
         rx_shift_ff        <= rx_shift_in;
         mode_byte_ff       <= mode_byte_in;
         button_ff          <= button_in;
         stick_ff           <= stick_in;
         motor_small_ff     <= motor_small_in;
         motor_large_ff     <= motor_large_in;
         out_valid_ff       <= out_valid_in;
         skid_valid_ff      <= skid_valid_in;
      end
   end

   // Payload of the output buffer needs no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      skid_data_ff <= skid_data_in;
      skid_last_ff <= skid_last_in;
   end

   // The skid register only fills behind a full output register.
   `ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid word without output word")
   // The bit counter only moves inside a frame.
   `ASSERT_SAME(a_bits_in_frame, clock, reset, bit_count_ff != '0, busy_ff, "bit count outside a frame")
   // The byte counter never passes the last byte of the frame.
   `ASSERT_SAME(a_byte_range, clock, reset, 1'b1, byte_count_ff <= LAST_BYTE, "byte count past frame end")
   // Each finished frame flips the frame kind.
   `ASSERT_NEXT(a_kind_flips, clock, reset, accept && !cmd && busy_ff && frame_end, frame_is_rumble_ff != $past(frame_is_rumble_ff), "frame kind did not alternate")

endmodule

[sim/gamepad_serial_poll_decoder_top_tb.sv]
// Self-checking testbench for gamepad_serial_poll_decoder_top: drives poll frames of bit ticks,
// predicts every result word and compares it field by field. Depends on gspd_pkg and the RTL.
`timescale 1ns / 1ps

module gamepad_serial_poll_decoder_top_tb;
   import gspd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   // One input word: a bit tick or a frame start, with the bit seen from the pad.
   typedef struct {
      logic cmd;
      logic din;
   } pad_tick_type;

   // One result word, laid out as {rsp_tlast, rsp_tdata}.
   typedef struct packed {
      logic       frame_done;
      logic       mode_red;
      logic [7:0] right_y;
      logic [7:0] right_x;
      logic [7:0] left_y;
      logic [7:0] left_x;
      logic [4:0] key;
      logic       select_active;
      logic       dout;
   } poll_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [0] din, [7:1] zero
   logic        req_tuser = 1'b0; // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [0] dout, [1] select_active, [6:2] key, [14:7] left_x,
                                  // [22:15] left_y, [30:23] right_x, [38:31] right_y,
                                  // [39] mode_red
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   gamepad_serial_poll_decoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   pad_tick_type  pad_ticks[$];
   poll_word_type poll_words_due[$];
   int         errors = 0;
   int         quiet_cycles = 0;
   bit         req_taken = 1'b0;
   bit         tx_gaps_on = 1'b1;
   bit         rx_stalls_on = 1'b1;
   int         tx_hold = 0;
   int         rx_hold = 0;

   // Register copy and decoder state of the prediction.
   logic [7:0]  cfg_reg [0:4] = '{X_DEAD_LOW_RST, X_DEAD_HIGH_RST, Y_DEAD_LOW_RST,
                                  Y_DEAD_HIGH_RST, RUMBLE_RST};
   bit          pm_rumble_frame = 1'b0;
   bit          pm_busy = 1'b0;
   logic [3:0]  pm_byte_cnt = '0;
   logic [2:0]  pm_bit_cnt = '0;
   logic [7:0]  pm_shift = '0;
   logic [7:0]  pm_mode = '0;
   logic [15:0] pm_buttons = 16'hFFFF;
   logic [7:0]  pm_sticks [0:3] = '{8'd0, 8'd0, 8'd0, 8'd0};
   logic [7:0]  pm_motor_small = '0;
   logic [7:0]  pm_motor_large = '0;

   // Centre a stick byte when it lies strictly between the two bounds.
   function automatic logic [7:0] dead_snap(input logic [7:0] v, input logic [7:0] lo,
                                            input logic [7:0] hi, input logic [7:0] centre);
      return ((v > lo) && (v < hi)) ? centre : v;
   endfunction

   // Work out the result word of one accepted input word and advance the decoder state.
   task automatic predict_poll_word(input logic cmd, input logic din);
      poll_word_type w;
      logic [7:0] tx;
      logic [7:0] rx, ry, lx, ly;
      logic [4:0] k;
      w = '0;
      if (cmd) begin
         pm_busy = 1'b1;
         pm_byte_cnt = '0;
         pm_bit_cnt = '0;
         pm_shift = '0;
         w.select_active = 1'b1;
      end else if (pm_busy) begin
         if (pm_byte_cnt == 4'd0) tx = TX_START;
         else if (pm_byte_cnt == 4'd1) tx = TX_POLL;
         else if (pm_rumble_frame && pm_byte_cnt == BYTE_MOTOR_S) tx = pm_motor_small;
         else if (pm_rumble_frame && pm_byte_cnt == BYTE_MOTOR_L) tx = pm_motor_large;
         else tx = TX_IDLE;
         w.dout = tx[pm_bit_cnt];
         w.select_active = 1'b1;
         pm_shift = {din, pm_shift[7:1]};
         if (pm_bit_cnt != 3'd7) begin
            pm_bit_cnt = pm_bit_cnt + 3'd1;
         end else begin
            // A whole byte has arrived; read frames keep the bytes of interest.
            if (!pm_rumble_frame) begin
               case (pm_byte_cnt)
                  BYTE_MODE:   pm_mode = pm_shift;
                  BYTE_BTN_LO: pm_buttons[7:0] = pm_shift;
                  BYTE_BTN_HI: pm_buttons[15:8] = pm_shift;
                  BYTE_RX:     pm_sticks[0] = pm_shift;
                  BYTE_RY:     pm_sticks[1] = pm_shift;
                  BYTE_LX:     pm_sticks[2] = pm_shift;
                  BYTE_LY:     pm_sticks[3] = pm_shift;
                  default: ;
               endcase
            end
            pm_bit_cnt = '0;
            pm_shift = '0;
            if (int'(pm_byte_cnt) + 1 < FRAME_BYTES_DEF) begin
               pm_byte_cnt = pm_byte_cnt + 4'd1;
            end else begin
               // End of frame: a read frame reports its decode and picks the motors.
               pm_busy = 1'b0;
               pm_byte_cnt = '0;
               if (!pm_rumble_frame) begin
                  k = KEY_NONE;
                  for (int i = 15; i >= 0; i--) begin
                     if (!pm_buttons[i]) k = 5'(i + 1);
                  end
                  if (k == KEY_LARGE_A || k == KEY_LARGE_B) begin
                     pm_motor_small = '0;
                     pm_motor_large = cfg_reg[CSR_RUMBLE];
                  end else if (k == KEY_SMALL_A || k == KEY_SMALL_B) begin
                     pm_motor_small = cfg_reg[CSR_RUMBLE];
                     pm_motor_large = '0;
                  end else begin
                     pm_motor_small = '0;
                     pm_motor_large = '0;
                  end
                  rx = dead_snap(pm_sticks[0], cfg_reg[CSR_X_DEAD_LOW], cfg_reg[CSR_X_DEAD_HIGH],
                                 X_CENTRE);
                  ry = dead_snap(pm_sticks[1], cfg_reg[CSR_Y_DEAD_LOW], cfg_reg[CSR_Y_DEAD_HIGH],
                                 Y_CENTRE);
                  lx = dead_snap(pm_sticks[2], cfg_reg[CSR_X_DEAD_LOW], cfg_reg[CSR_X_DEAD_HIGH],
                                 X_CENTRE);
                  ly = dead_snap(pm_sticks[3], cfg_reg[CSR_Y_DEAD_LOW], cfg_reg[CSR_Y_DEAD_HIGH],
                                 Y_CENTRE);
                  w.frame_done = 1'b1;
                  w.key = k;
                  w.left_x = lx ^ 8'h80;
                  w.left_y = Y_CENTRE - ly;
                  w.right_x = rx ^ 8'h80;
                  w.right_y = Y_CENTRE - ry;
                  w.mode_red = (pm_mode == MODE_RED);
               end
               pm_rumble_frame = !pm_rumble_frame;
            end
         end
      end
      poll_words_due.push_back(w);
   endtask

   // Report one field that differs; returns the number of mismatches.
   function automatic int field_diff(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int idle_len(input bit on);
      int r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Sample both channels, check results, predict accepted words and watch for a hang.
   always @(posedge clock) begin
      poll_word_type got, want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tlast, rsp_tdata};
            if (poll_words_due.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = poll_words_due.pop_front();
               errors += field_diff("dout", 8'(want.dout), 8'(got.dout));
               errors += field_diff("select_active", 8'(want.select_active),
                                    8'(got.select_active));
               errors += field_diff("frame_done", 8'(want.frame_done), 8'(got.frame_done));
               errors += field_diff("key", 8'(want.key), 8'(got.key));
               errors += field_diff("left_x", want.left_x, got.left_x);
               errors += field_diff("left_y", want.left_y, got.left_y);
               errors += field_diff("right_x", want.right_x, got.right_x);
               errors += field_diff("right_y", want.right_y, got.right_y);
               errors += field_diff("mode_red", 8'(want.mode_red), 8'(got.mode_red));
            end
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken) predict_poll_word(req_tuser, req_tdata[0]);
         if (req_taken || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("gamepad_serial_poll_decoder_top verification failed");
            $finish;
         end
      end
   end

   // Input driver: offers the next pending word after the previous one was taken and any gap.
   always @(negedge clock) begin
      pad_tick_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (tx_hold > 0) begin
            tx_hold--;
            req_tvalid <= 1'b0;
         end else if (pad_ticks.size() != 0) begin
            t = pad_ticks.pop_front();
            req_tuser <= t.cmd;
            req_tdata <= {7'd0, t.din};
            req_tvalid <= 1'b1;
            tx_hold = idle_len(tx_gaps_on);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rx_hold = idle_len(rx_stalls_on);
      end
   end

   // Queue one frame: a start word, then nbits ticks carrying the pad's bytes LSB first.
   task automatic queue_frame(input logic [7:0] mode, input logic [15:0] buttons,
                              input logic [7:0] rx, input logic [7:0] ry,
                              input logic [7:0] lx, input logic [7:0] ly, input int nbits);
      logic [7:0] pad_bytes [0:8];
      pad_bytes[0] = 8'($urandom);
      pad_bytes[1] = mode;
      pad_bytes[2] = 8'($urandom);
      pad_bytes[3] = buttons[7:0];
      pad_bytes[4] = buttons[15:8];
      pad_bytes[5] = rx;
      pad_bytes[6] = ry;
      pad_bytes[7] = lx;
      pad_bytes[8] = ly;
      pad_ticks.push_back('{cmd: 1'b1, din: 1'($urandom)});
      for (int i = 0; i < nbits; i++) begin
         pad_ticks.push_back('{cmd: 1'b0, din: pad_bytes[i / 8][i % 8]});
      end
   endtask

   // Button word whose lowest clear bit gives a chosen key, the motor keys favoured.
   function automatic logic [15:0] pick_buttons();
      logic [15:0] w;
      int k;
      w = 16'($urandom);
      if ($urandom_range(0, 99) < 40) k = $urandom_range(KEY_LARGE_A, KEY_SMALL_B);
      else k = $urandom_range(0, 16);
      if (k == 0) return 16'hFFFF;
      for (int i = 0; i < k - 1; i++) w[i] = 1'b1;
      w[k - 1] = 1'b0;
      return w;
   endfunction

   // Stick byte, often on or next to a deadzone bound, at an extreme or at a centre.
   function automatic logic [7:0] pick_stick(input logic [7:0] lo, input logic [7:0] hi);
      case ($urandom_range(0, 3))
         0: return 8'($urandom);
         1: return lo + 8'($urandom_range(0, 2)) - 8'd1;
         2: return hi + 8'($urandom_range(0, 2)) - 8'd1;
         default: begin
            case ($urandom_range(0, 3))
               0: return 8'd0;
               1: return 8'd255;
               2: return X_CENTRE;
               default: return Y_CENTRE;
            endcase
         end
      endcase
   endfunction

   task automatic queue_random_frame(input int nbits);
      logic [7:0] mode;
      case ($urandom_range(0, 3))
         0, 1: mode = MODE_RED;
         2: mode = MODE_RED + 8'($urandom_range(0, 2)) - 8'd1;
         default: mode = 8'($urandom);
      endcase
      queue_frame(mode, pick_buttons(),
                  pick_stick(cfg_reg[CSR_X_DEAD_LOW], cfg_reg[CSR_X_DEAD_HIGH]),
                  pick_stick(cfg_reg[CSR_Y_DEAD_LOW], cfg_reg[CSR_Y_DEAD_HIGH]),
                  pick_stick(cfg_reg[CSR_X_DEAD_LOW], cfg_reg[CSR_X_DEAD_HIGH]),
                  pick_stick(cfg_reg[CSR_Y_DEAD_LOW], cfg_reg[CSR_Y_DEAD_HIGH]), nbits);
   endtask

   // Mostly whole frames, with some abandoned frames and stray ticks; ends on a whole frame.
   task automatic queue_phase(input int min_words, input int min_frames);
      int frames;
      int start_size;
      int r;
      frames = 0;
      start_size = pad_ticks.size();
      while (pad_ticks.size() - start_size < min_words || frames < min_frames) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            queue_random_frame(8 * FRAME_BYTES_DEF);
            frames++;
         end else if (r < 90) begin
            queue_random_frame($urandom_range(0, 8 * FRAME_BYTES_DEF - 1));
         end else begin
            repeat ($urandom_range(1, 4)) pad_ticks.push_back('{cmd: 1'b0, din: 1'($urandom)});
         end
      end
      queue_random_frame(8 * FRAME_BYTES_DEF);
   endtask

   // Wait until every word has gone in and every result has come back, then let it settle.
   task automatic wait_drained();
      while (pad_ticks.size() != 0 || req_tvalid || poll_words_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] v);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      cfg_reg[idx] = v;
   endtask

   task automatic set_registers(input logic [7:0] xl, input logic [7:0] xh,
                                input logic [7:0] yl, input logic [7:0] yh,
                                input logic [7:0] level);
      write_csr(CSR_X_DEAD_LOW, xl);
      write_csr(CSR_X_DEAD_HIGH, xh);
      write_csr(CSR_Y_DEAD_LOW, yl);
      write_csr(CSR_Y_DEAD_HIGH, yh);
      write_csr(CSR_RUMBLE, level);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Stimulus: directed frames under the reset settings, then random phases.
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Ticks while idle are ignored.
      pad_ticks.push_back('{cmd: 1'b0, din: 1'b1});
      pad_ticks.push_back('{cmd: 1'b0, din: 1'b0});
      // Nothing pressed, red mode, sticks at the extremes and centres.
      queue_frame(MODE_RED, 16'hFFFF, 8'd0, 8'd255, X_CENTRE, Y_CENTRE, 72);
      queue_frame(8'hFF, 16'h0000, 8'd255, 8'd0, 8'd0, 8'd255, 72);
      // Key 9 asks for the large motor; sticks on and just inside the bounds.
      queue_frame(8'h72, 16'hFEFF, 8'd123, 8'd122, 8'd124, 8'd131, 72);
      queue_frame(8'h00, 16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 72);
      // A start while busy abandons the frame; key 10 asks for the small motor.
      queue_frame(8'h00, 16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 20);
      queue_frame(8'h74, 16'hFDFF, 8'd133, 8'd132, 8'd132, 8'd121, 72);
      queue_frame(8'hFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255, 72);
      // Key 1 wins over every other pressed key.
      queue_frame(MODE_RED, 16'h0000, 8'd128, 8'd127, 8'd1, 8'd254, 72);
      queue_frame(8'h00, 16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0, 72);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         tx_gaps_on = (p != 2);
         rx_stalls_on = (p != 2 && p != 4);
         case (p)
            0: set_registers(8'd0, 8'd255, 8'd0, 8'd255, 8'h80);
            1: set_registers(8'd255, 8'd0, 8'd255, 8'd0, 8'd0);
            2: set_registers(8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
            3: set_registers(8'd100, 8'd102, 8'd200, 8'd202, 8'($urandom_range(1, 254)));
            4: set_registers(8'd127, 8'd129, 8'd126, 8'd128, 8'd1);
            default: set_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom));
         endcase
         queue_phase(70, 1);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("gamepad_serial_poll_decoder_top verification clean");
      end else begin
         $display("gamepad_serial_poll_decoder_top verification failed");
      end
      $finish;
   end

endmodule
